>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

>>> rtl/core/nsfc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter package
// Types, character codes, status codes and helpers of the sentence filter.
// ----------------------------------------------------------------------------
package nsfc_pkg;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_T1,
        PH_T2,
        PH_S1,
        PH_S2,
        PH_S3,
        PH_BODY,
        PH_C1,
        PH_C2
    } t_phase;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;

    localparam logic [23:0] TYPE_RMC = 24'h524D43;
    localparam logic [23:0] TYPE_GGA = 24'h474741;

    localparam logic [2:0] ST_GOOD     = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_BAD_HEX  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_ABORTED  = 3'd4;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_GGA   = 2'd2;

    localparam logic CFG_VERIFY  = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic [7:0] MAX_LEN_RESET = 8'd128;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        last;
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [15:0] mismatch_count;
    } t_result;

    // Bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h41 + 8'd10);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h61 + 8'd10);
        end
        return v;
    endfunction

    function automatic t_result make_result(input logic [7:0] data_byte,
                                            input logic present,
                                            input logic last,
                                            input logic [2:0] status,
                                            input logic [1:0] kind,
                                            input logic [15:0] count);
        t_result r;
        r.data_byte      = data_byte;
        r.byte_present   = present;
        r.last           = last;
        r.status         = last ? status : ST_GOOD;
        r.kind           = last ? kind : KIND_OTHER;
        r.mismatch_count = count;
        return r;
    endfunction

endpackage

>>> rtl/core/nmea_sentence_filter_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence filter and checksum checker
// Results are registered in the output buffer before they appear on the master side.
// Throughput: one byte per cycle while the output buffer has space; the byte that
// completes the sentence prefix holds the slave side while the prefix is replayed.
// A two-entry output buffer lets requests flow while one result waits.
// Reset is synchronous, active low: hunting, counter zero, verify on, limit 128.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmea_sentence_filter_checker #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] data_byte, [23:8] mismatch_count
    output logic        o_m_axis_tlast,
    output logic [7:0]  o_m_axis_tuser,   // [0] byte_present, [3:1] status, [5:4] kind
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);
    import nsfc_pkg::*;

    logic                    r_verify;
    logic [7:0]              r_max_len;

    t_phase                  r_phase, n_phase;
    logic [7:0]              r_let1, n_let1;
    logic [7:0]              r_let2, n_let2;
    logic [7:0]              r_let3, n_let3;
    logic [7:0]              r_xor, n_xor;
    logic [7:0]              r_rxsum, n_rxsum;
    logic [7:0]              r_count, n_count;
    logic                    r_hex_err, n_hex_err;
    logic                    r_await, n_await;
    logic [1:0]              r_kind, n_kind;
    logic [COUNTER_BITS-1:0] r_mcnt, n_mcnt;
    logic                    r_burst, n_burst;
    logic [2:0]              r_bidx, n_bidx;

    logic                    r_o_valid;
    t_result                 r_o_data;
    logic                    r_skid_valid;
    t_result                 r_skid_data;

    logic                    w_space;
    logic                    w_accept;
    logic                    w_pop;
    logic                    w_gen_valid;
    t_result                 w_gen;
    logic [7:0]              w_byte;
    logic [7:0]              w_cnt_inc;
    logic                    w_too_long;
    logic [31:0]             w_cnt_wide;
    logic [15:0]             w_cnt16;

    assign w_space         = !r_skid_valid;
    assign o_s_axis_tready = w_space && !r_burst;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = r_o_valid && i_m_axis_tready;
    assign w_byte          = i_s_axis_tdata;
    assign w_cnt_inc       = (r_count != 8'hFF) ? r_count + 8'd1 : r_count;
    assign w_too_long      = (w_cnt_inc >= r_max_len);

    always_comb begin
        logic [4:0] hv;
        logic [7:0] pre_byte;
        logic [7:0] new_sum;
        logic       new_err;
        logic [2:0] st;
        hv          = hex_value(w_byte);
        pre_byte    = CH_DOLLAR;
        new_sum     = r_rxsum;
        new_err     = r_hex_err;
        st          = ST_GOOD;
        n_phase     = r_phase;
        n_let1      = r_let1;
        n_let2      = r_let2;
        n_let3      = r_let3;
        n_xor       = r_xor;
        n_rxsum     = r_rxsum;
        n_count     = r_count;
        n_hex_err   = r_hex_err;
        n_await     = r_await;
        n_kind      = r_kind;
        n_mcnt      = r_mcnt;
        n_burst     = r_burst;
        n_bidx      = r_bidx;
        w_gen_valid = 1'b0;
        w_cnt_wide  = 32'(r_mcnt);
        w_cnt16     = w_cnt_wide[15:0];
        w_gen       = make_result(8'd0, 1'b0, 1'b0, ST_GOOD, KIND_OTHER, w_cnt16);

        if (r_burst) begin
            if (w_space) begin
                unique case (r_bidx)
                    3'd1:    pre_byte = CH_G;
                    3'd2:    pre_byte = CH_P;
                    3'd3:    pre_byte = r_let1;
                    3'd4:    pre_byte = r_let2;
                    default: pre_byte = r_let3;
                endcase
                n_count     = w_cnt_inc;
                w_gen_valid = 1'b1;
                w_gen       = make_result(pre_byte, 1'b1, w_too_long,
                                          r_hex_err ? ST_BAD_HEX : ST_TOO_LONG,
                                          r_kind, w_cnt16);
                if (w_too_long) begin
                    n_burst = 1'b0;
                    n_phase = PH_HUNT;
                end else if (r_bidx == 3'd5) begin
                    n_burst = 1'b0;
                end else begin
                    n_bidx = r_bidx + 3'd1;
                end
            end
        end else if (w_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (w_byte == CH_DOLLAR) n_phase = PH_T1;
                end
                PH_T1: n_phase = (w_byte == CH_G) ? PH_T2 : PH_HUNT;
                PH_T2: n_phase = (w_byte == CH_P) ? PH_S1 : PH_HUNT;
                PH_S1: begin
                    if (w_byte == CH_G || w_byte == CH_R) begin
                        n_let1  = w_byte;
                        n_phase = PH_S2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_S2: begin
                    if (w_byte == CH_G || w_byte == CH_M) begin
                        n_let2  = w_byte;
                        n_phase = PH_S3;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_S3: begin
                    if (w_byte == CH_A || w_byte == CH_C) begin
                        n_let3      = w_byte;
                        n_xor       = CH_G ^ CH_P ^ r_let1 ^ r_let2 ^ w_byte;
                        n_rxsum     = 8'd0;
                        n_count     = 8'd1;
                        n_hex_err   = 1'b0;
                        n_kind      = KIND_OTHER;
                        n_await     = 1'b1;
                        w_gen_valid = 1'b1;
                        if (r_max_len <= 8'd1) begin
                            n_phase = PH_HUNT;
                            w_gen   = make_result(CH_DOLLAR, 1'b1, 1'b1, ST_TOO_LONG,
                                                  KIND_OTHER, w_cnt16);
                        end else begin
                            n_phase = PH_BODY;
                            n_burst = 1'b1;
                            n_bidx  = 3'd1;
                            w_gen   = make_result(CH_DOLLAR, 1'b1, 1'b0, ST_GOOD,
                                                  KIND_OTHER, w_cnt16);
                        end
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    w_gen_valid = 1'b1;
                    if (w_byte == CH_DOLLAR) begin
                        n_phase = PH_HUNT;
                        w_gen   = make_result(8'd0, 1'b0, 1'b1, ST_ABORTED, r_kind,
                                              w_cnt16);
                    end else begin
                        if (r_await) begin
                            n_await = 1'b0;
                            if (w_byte == CH_COMMA && {r_let1, r_let2, r_let3} == TYPE_RMC) begin
                                n_kind = KIND_RMC;
                            end else if (w_byte == CH_COMMA &&
                                         {r_let1, r_let2, r_let3} == TYPE_GGA) begin
                                n_kind = KIND_GGA;
                            end else begin
                                n_kind = KIND_OTHER;
                            end
                        end
                        if (w_byte == CH_STAR) begin
                            n_phase = PH_C1;
                        end else begin
                            n_xor = r_xor ^ w_byte;
                        end
                        n_count = w_cnt_inc;
                        if (w_too_long) n_phase = PH_HUNT;
                        w_gen = make_result(w_byte, 1'b1, w_too_long,
                                            r_hex_err ? ST_BAD_HEX : ST_TOO_LONG,
                                            n_kind, w_cnt16);
                    end
                end
                PH_C1: begin
                    if (hv[4]) begin
                        new_err = 1'b1;
                    end else begin
                        new_sum = {r_rxsum[3:0], hv[3:0]};
                    end
                    n_hex_err   = new_err;
                    n_rxsum     = new_sum;
                    n_count     = w_cnt_inc;
                    n_phase     = w_too_long ? PH_HUNT : PH_C2;
                    w_gen_valid = 1'b1;
                    w_gen       = make_result(w_byte, 1'b1, w_too_long,
                                              new_err ? ST_BAD_HEX : ST_TOO_LONG,
                                              r_kind, w_cnt16);
                end
                PH_C2: begin
                    if (hv[4]) begin
                        new_err = 1'b1;
                    end else begin
                        new_sum = {r_rxsum[3:0], hv[3:0]};
                    end
                    n_hex_err = new_err;
                    n_rxsum   = new_sum;
                    n_count   = w_cnt_inc;
                    priority if (new_err) begin
                        st = ST_BAD_HEX;
                    end else if (w_too_long) begin
                        st = ST_TOO_LONG;
                    end else if (r_verify && (r_xor != new_sum)) begin
                        st = ST_MISMATCH;
                        if (r_mcnt != {COUNTER_BITS{1'b1}}) begin
                            n_mcnt = r_mcnt + COUNTER_BITS'(1);
                        end
                    end else begin
                        st = ST_GOOD;
                    end
                    w_cnt_wide  = 32'(n_mcnt);
                    w_cnt16     = w_cnt_wide[15:0];
                    n_phase     = PH_HUNT;
                    w_gen_valid = 1'b1;
                    w_gen       = make_result(w_byte, 1'b1, 1'b1, st, r_kind, w_cnt16);
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verify  <= 1'b1;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_VERIFY:  r_verify  <= i_cfg_wdata[0];
                CFG_MAX_LEN: r_max_len <= i_cfg_wdata;
                default:     r_verify  <= r_verify;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_let1    <= 8'd0;
            r_let2    <= 8'd0;
            r_let3    <= 8'd0;
            r_xor     <= 8'd0;
            r_rxsum   <= 8'd0;
            r_count   <= 8'd0;
            r_hex_err <= 1'b0;
            r_await   <= 1'b0;
            r_kind    <= KIND_OTHER;
            r_mcnt    <= '0;
            r_burst   <= 1'b0;
            r_bidx    <= 3'd0;
        end else begin
            r_phase   <= n_phase;
            r_let1    <= n_let1;
            r_let2    <= n_let2;
            r_let3    <= n_let3;
            r_xor     <= n_xor;
            r_rxsum   <= n_rxsum;
            r_count   <= n_count;
            r_hex_err <= n_hex_err;
            r_await   <= n_await;
            r_kind    <= n_kind;
            r_mcnt    <= n_mcnt;
            r_burst   <= n_burst;
            r_bidx    <= n_bidx;
        end
    end

    // Results enter the output register, or the skid entry when the output
    // register is held by the downstream side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_o_valid || w_pop) begin
                if (r_skid_valid) begin
                    r_o_valid    <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_o_valid <= w_gen_valid;
                end
            end else if (w_gen_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || w_pop) begin
            if (r_skid_valid) begin
                r_o_data <= r_skid_data;
            end else if (w_gen_valid) begin
                r_o_data <= w_gen;
            end
        end else if (w_gen_valid) begin
            r_skid_data <= w_gen;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_data.mismatch_count, r_o_data.data_byte};
    assign o_m_axis_tlast  = r_o_data.last;
    assign o_m_axis_tuser  = {2'b00, r_o_data.kind, r_o_data.status,
                              r_o_data.byte_present};

    `ASSERT_PROP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid |-> r_o_valid)
    `ASSERT_PROP(a_burst_blocks_in, i_clk, i_rst_n,
                 r_burst |-> (!o_s_axis_tready && r_bidx >= 3'd1 && r_bidx <= 3'd5))
    `ASSERT_PROP(a_abort_marker, i_clk, i_rst_n,
                 (r_o_valid && !r_o_data.byte_present) |->
                 (r_o_data.last && r_o_data.status == ST_ABORTED))
    `ASSERT_PROP(a_plain_byte_clean, i_clk, i_rst_n,
                 (r_o_valid && !r_o_data.last) |->
                 (r_o_data.status == ST_GOOD && r_o_data.kind == KIND_OTHER))
    `ASSERT_NEVER(a_no_gen_when_full, i_clk, i_rst_n, w_gen_valid && r_skid_valid)

endmodule
